// ===== rtl/assert_macros.svh =====
// Assertion macros used by the fault monitor top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BCFM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bcfm assertion failed");

// Next-cycle implication, checked outside reset.
`define BCFM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bcfm assertion failed");

`endif

// ===== rtl/bcfm_pkg.sv =====
// Types, codes and constants of the battery cell fault monitor.
`timescale 1ns / 1ps

package bcfm_pkg;

  localparam int MV_W       = 16;
  localparam int TIME_W     = 32;
  localparam int HZ_W       = 11;
  localparam int CODE_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Safety state codes
  typedef enum logic [CODE_W-1:0] {
    CODE_SAFE   = 3'd0,
    CODE_WEAK   = 3'd1,
    CODE_OVER   = 3'd2,
    CODE_SENSOR = 3'd3,
    CODE_RAPID  = 3'd4
  } safety_code_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WEAK_LIMIT   = 3'd0,
    CFG_OVER_LIMIT   = 3'd1,
    CFG_CHANGE_LIMIT = 3'd2,
    CFG_SENSOR_LOW   = 3'd3,
    CFG_SENSOR_HIGH  = 3'd4,
    CFG_RECOVERY     = 3'd5
  } cfg_index_t;

  // Register reset values
  localparam logic [MV_W-1:0]   RST_WEAK_LIMIT   = 16'd3000;
  localparam logic [MV_W-1:0]   RST_OVER_LIMIT   = 16'd4200;
  localparam logic [MV_W-1:0]   RST_CHANGE_LIMIT = 16'd300;
  localparam logic [MV_W-1:0]   RST_SENSOR_LOW   = 16'd500;
  localparam logic [MV_W-1:0]   RST_SENSOR_HIGH  = 16'd4300;
  localparam logic [TIME_W-1:0] RST_RECOVERY     = 32'd3000;

  // Buzzer tones
  localparam logic [HZ_W-1:0] HZ_SILENT = 11'd0;
  localparam logic [HZ_W-1:0] HZ_CELL   = 11'd1000;
  localparam logic [HZ_W-1:0] HZ_SENSOR = 11'd1500;
  localparam logic [HZ_W-1:0] HZ_RAPID  = 11'd1200;

  // Limits as seen by the datapath
  typedef struct packed {
    logic [MV_W-1:0]   weak_limit_mv;
    logic [MV_W-1:0]   over_limit_mv;
    logic [MV_W-1:0]   change_limit_mv;
    logic [MV_W-1:0]   sensor_low_mv;
    logic [MV_W-1:0]   sensor_high_mv;
    logic [TIME_W-1:0] recovery_delay_ms;
  } cfg_t;

  function automatic logic [HZ_W-1:0] buzzer_hz(input safety_code_t code);
    logic [HZ_W-1:0] hz;
    case (code)
      CODE_WEAK, CODE_OVER: hz = HZ_CELL;
      CODE_SENSOR:          hz = HZ_SENSOR;
      CODE_RAPID:           hz = HZ_RAPID;
      default:              hz = HZ_SILENT;
    endcase
    return hz;
  endfunction

endpackage

// ===== rtl/bcfm_ifs.sv =====
// Channel interfaces: sample items, result items and register writes.
`timescale 1ns / 1ps

interface bcfm_item_if #(parameter int CELL_COUNT = 4);
  import bcfm_pkg::*;
  logic                             valid;
  logic                             ready;
  logic [TIME_W-1:0]                now_ms;
  logic [CELL_COUNT-1:0][MV_W-1:0]  cell_mv;

  modport source (output valid, output now_ms, output cell_mv, input ready);
  modport sink   (input valid, input now_ms, input cell_mv, output ready);
endinterface

interface bcfm_result_if;
  import bcfm_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] safety_code;
  logic              relay_closed;
  logic              led_lit;
  logic [HZ_W-1:0]   buzzer_hz;

  modport source (output valid, output safety_code, output relay_closed,
                  output led_lit, output buzzer_hz, input ready);
  modport sink   (input valid, input safety_code, input relay_closed,
                  input led_lit, input buzzer_hz, output ready);
endinterface

interface bcfm_cfg_if;
  import bcfm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/bcfm_cfg_regs.sv =====
// Configuration register file of the fault monitor.
`timescale 1ns / 1ps

module bcfm_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  bcfm_cfg_if.sink       cfg_ch,
  output bcfm_pkg::cfg_t cfg
);
  import bcfm_pkg::*;

  cfg_t cfg_r;

  // Writes are always taken; unknown indexes are dropped
  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.weak_limit_mv     <= RST_WEAK_LIMIT;
      cfg_r.over_limit_mv     <= RST_OVER_LIMIT;
      cfg_r.change_limit_mv   <= RST_CHANGE_LIMIT;
      cfg_r.sensor_low_mv     <= RST_SENSOR_LOW;
      cfg_r.sensor_high_mv    <= RST_SENSOR_HIGH;
      cfg_r.recovery_delay_ms <= RST_RECOVERY;
    end else if (cfg_ch.valid) begin
      case (cfg_index_t'(cfg_ch.index))
        CFG_WEAK_LIMIT:   cfg_r.weak_limit_mv     <= cfg_ch.data[MV_W-1:0];
        CFG_OVER_LIMIT:   cfg_r.over_limit_mv     <= cfg_ch.data[MV_W-1:0];
        CFG_CHANGE_LIMIT: cfg_r.change_limit_mv   <= cfg_ch.data[MV_W-1:0];
        CFG_SENSOR_LOW:   cfg_r.sensor_low_mv     <= cfg_ch.data[MV_W-1:0];
        CFG_SENSOR_HIGH:  cfg_r.sensor_high_mv    <= cfg_ch.data[MV_W-1:0];
        CFG_RECOVERY:     cfg_r.recovery_delay_ms <= cfg_ch.data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/battery_cell_fault_monitor_top.sv =====
// Top level of the battery cell fault monitor: sample checks, state and outputs.
//
//   channel  direction  carries
//   -------  ---------  ------------------------------------------------
//   in_ch    sink       now_ms, cell_mv[CELL_COUNT] (one sample item)
//   out_ch   source     safety_code, relay_closed, led_lit, buzzer_hz
//   cfg_ch   sink       index, data (register write, always ready)
//
// One item per cycle sustained while out_ch is ready; a result leaves through the
// sample register, then the result register. The state update and all cell
// compares sit between those two registers in one pass.
// Reset (rst_n low, synchronous) restores the default limits, safe state,
// first-sample flag and stopped timer. A stalled result holds the pipe; the
// sample register still takes an item whenever it is empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module battery_cell_fault_monitor_top #(
  parameter int CELL_COUNT = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  bcfm_cfg_if.sink     cfg_ch,
  bcfm_item_if.sink    in_ch,
  bcfm_result_if.source out_ch
);
  import bcfm_pkg::*;

  typedef logic [CELL_COUNT-1:0][MV_W-1:0] cells_t;

  cfg_t cfg;

  // Sample register
  logic              s1_valid_r;
  logic [TIME_W-1:0] s1_now_r;
  cells_t            s1_cells_r;

  // Monitor state
  safety_code_t      safety_r, safety_nxt;
  cells_t            prior_r, prior_nxt;
  logic              first_r, first_nxt;
  logic              timer_run_r, timer_run_nxt;
  logic [TIME_W-1:0] timer_start_r, timer_start_nxt;

  // Result register
  logic              out_valid_r;
  safety_code_t      out_code_r;
  logic              out_relay_r;
  logic              out_led_r;
  logic [HZ_W-1:0]   out_hz_r;

  // Check results
  logic              range_err, over_any, weak_any, rapid_any;
  logic [CELL_COUNT-1:0] diff_big, upd_mask;
  safety_code_t      fault;
  logic [TIME_W-1:0] start_eff, elapsed;

  logic in_accept, advance;

  bcfm_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Handshake: the sample moves on when the result register is free
  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_accept    = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_now_r   <= in_ch.now_ms;
      s1_cells_r <= in_ch.cell_mv;
    end
  end

  // Per-cell compares, all in parallel
  always_comb begin
    logic [MV_W-1:0] mv;
    logic [MV_W-1:0] diff;
    range_err = 1'b0;
    over_any  = 1'b0;
    weak_any  = 1'b0;
    for (int i = 0; i < CELL_COUNT; i++) begin
      mv   = s1_cells_r[i];
      diff = (mv >= prior_r[i]) ? (mv - prior_r[i]) : (prior_r[i] - mv);
      diff_big[i] = diff > cfg.change_limit_mv;
      if (mv < cfg.sensor_low_mv || mv > cfg.sensor_high_mv) range_err = 1'b1;
      if (mv > cfg.over_limit_mv) over_any = 1'b1;
      if (mv < cfg.weak_limit_mv) weak_any = 1'b1;
    end
  end

  // Prior readings refresh up to and including the first rapid cell
  always_comb begin
    logic blocked;
    blocked = 1'b0;
    for (int i = 0; i < CELL_COUNT; i++) begin
      upd_mask[i] = !blocked;
      if (diff_big[i]) blocked = 1'b1;
    end
  end

  // Prior readings, first-sample flag and fault priority
  always_comb begin
    prior_nxt = prior_r;
    first_nxt = first_r;
    rapid_any = 1'b0;
    if (!range_err) begin
      if (first_r) begin
        prior_nxt = s1_cells_r;
        first_nxt = 1'b0;
      end else begin
        for (int i = 0; i < CELL_COUNT; i++) begin
          if (upd_mask[i]) prior_nxt[i] = s1_cells_r[i];
        end
        rapid_any = |diff_big;
      end
    end

    if (range_err)      fault = CODE_SENSOR;
    else if (rapid_any) fault = CODE_RAPID;
    else if (over_any)  fault = CODE_OVER;
    else if (weak_any)  fault = CODE_WEAK;
    else                fault = CODE_SAFE;
  end

  // Recovery timer: elapsed time wraps modulo 2^32
  assign start_eff = timer_run_r ? timer_start_r : s1_now_r;
  assign elapsed   = s1_now_r - start_eff;

  always_comb begin
    if (fault != CODE_SAFE) begin
      timer_run_nxt   = 1'b0;
      timer_start_nxt = '0;
      safety_nxt      = fault;
    end else begin
      timer_run_nxt   = 1'b1;
      timer_start_nxt = start_eff;
      safety_nxt      = (elapsed >= cfg.recovery_delay_ms) ? CODE_SAFE : safety_r;
    end
  end

  // State update once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      safety_r      <= CODE_SAFE;
      prior_r       <= '0;
      first_r       <= 1'b1;
      timer_run_r   <= 1'b0;
      timer_start_r <= '0;
    end else if (advance) begin
      safety_r      <= safety_nxt;
      prior_r       <= prior_nxt;
      first_r       <= first_nxt;
      timer_run_r   <= timer_run_nxt;
      timer_start_r <= timer_start_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_code_r  <= safety_nxt;
      out_relay_r <= (safety_nxt == CODE_SAFE);
      out_led_r   <= (safety_nxt != CODE_SAFE);
      out_hz_r    <= buzzer_hz(safety_nxt);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.safety_code  = out_code_r;
  assign out_ch.relay_closed = out_relay_r;
  assign out_ch.led_lit      = out_led_r;
  assign out_ch.buzzer_hz    = out_hz_r;

  // Checks
  `BCFM_ASSERT_IMP(a_no_overwrite, clk, rst_n, s1_valid_r && !advance, !in_ch.ready)
  `BCFM_ASSERT_NXT(a_fault_stops_timer, clk, rst_n,
                   advance && fault != CODE_SAFE, !timer_run_r && safety_r != CODE_SAFE)
  `BCFM_ASSERT_NXT(a_first_cleared, clk, rst_n, advance && !range_err, !first_r)
  `BCFM_ASSERT_NXT(a_timer_holds, clk, rst_n,
                   advance && timer_run_r && fault == CODE_SAFE, $stable(timer_start_r))
  `BCFM_ASSERT_IMP(a_relay_led, clk, rst_n, out_valid_r,
                   out_relay_r != out_led_r && out_relay_r == (out_hz_r == HZ_SILENT))

endmodule
